/* design/ppm_pkg.sv */
package ppm_pkg;

    localparam int TIME_W    = 32;
    localparam int REG_W     = 20;
    localparam int GAP_OUT_W = 28;
    localparam int CFG_IDX_W = 2;

    // channel slots per frame, sized to the slot_index and next_channel fields
    localparam int CHANNELS  = 4;

    // gap classes
    localparam logic [1:0] CLS_SYNC  = 2'd0;
    localparam logic [1:0] CLS_PULSE = 2'd1;
    localparam logic [1:0] CLS_SHORT = 2'd2;
    localparam logic [1:0] CLS_LONG  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd2;

    localparam logic [REG_W-1:0] SYNC_MIN_RST  = 20'd30000;
    localparam logic [REG_W-1:0] PULSE_MIN_RST = 20'd8000;
    localparam logic [REG_W-1:0] PULSE_MAX_RST = 20'd22000;

    typedef struct packed {
        logic [REG_W-1:0] sync_min_us;
        logic [REG_W-1:0] pulse_min_us;
        logic [REG_W-1:0] pulse_max_us;
    } ppm_cfg_t;

    typedef struct packed {
        logic [GAP_OUT_W-1:0] gap_us;
        logic [1:0]           gap_class;
        logic                 slot_written;
        logic [1:0]           slot_index;
        logic [2:0]           next_channel;
        logic                 frame_done;
        logic [TIME_W-1:0]    frames_seen;
        logic [TIME_W-1:0]    edges_seen;
    } ppm_result_t;

    // number of trailing zero bits of a positive constant, counting at most ten
    function automatic int ppm_tz(input int value);
        int n;
        int v;
        n = 0;
        v = value;
        for (int i = 0; i < 10; i++) begin
            if (v[0] == 1'b0) begin
                n = n + 1;
                v = v >> 1;
            end
        end
        return n;
    endfunction

endpackage

/* design/ppm_gap_unit.sv */
module ppm_gap_unit
    import ppm_pkg::*;
#(
    parameter int TICKS_PER_US = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [TIME_W-1:0] capture_time,
    output logic              out_valid,
    output logic [TIME_W-1:0] gap
);

    // divide by 2^K * D_ODD: shift out K bits, then exact reciprocal multiply
    localparam int K     = ppm_tz(TICKS_PER_US);
    localparam int D_ODD = TICKS_PER_US >> K;
    localparam int N     = TIME_W - K;
    localparam int L     = $clog2(D_ODD);
    localparam longint unsigned MUL_FULL = ((64'd1 << (N + L)) / D_ODD) + 64'd1;
    localparam logic [N:0] MUL_C = MUL_FULL[N:0];

    logic [TIME_W-1:0] prev_reg;
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_ticks_reg;
    logic              s2_valid_reg;
    logic [2*N:0]      s2_prod_reg;

    logic [TIME_W-1:0] ticks_next;
    logic [N-1:0]      ticks_hi;
    logic [2*N:0]      prod_next;
    logic [2*N:0]      quot_full;

    assign ticks_next = capture_time - prev_reg;
    assign ticks_hi   = s1_ticks_reg[TIME_W-1:K];
    assign prod_next  = {{(N+1){1'b0}}, ticks_hi} * {{N{1'b0}}, MUL_C};
    assign quot_full  = s2_prod_reg >> (N + L);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (in_valid) begin
                prev_reg <= capture_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ticks_reg <= ticks_next;
            s2_prod_reg  <= prod_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign gap       = quot_full[TIME_W-1:0];

endmodule

/* design/ppm_frame_tracker.sv */
module ppm_frame_tracker
    import ppm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [TIME_W-1:0] gap,
    input  ppm_cfg_t          cfg,
    output logic              out_valid,
    output ppm_result_t       result
);

    localparam int CW = $clog2(CHANNELS + 1);

    logic [CW-1:0]     chan_reg;
    logic [CW-1:0]     chan_next;
    logic [TIME_W-1:0] frames_reg;
    logic [TIME_W-1:0] frames_next;
    logic [TIME_W-1:0] edges_reg;
    logic [TIME_W-1:0] edges_next;
    logic              valid_reg;
    ppm_result_t       res_reg;
    ppm_result_t       res_next;

    logic [CW+2:0]     cur_ext;
    logic [CW+2:0]     nxt_ext;
    logic              is_sync;
    logic              in_range;
    logic              too_short;

    assign is_sync   = gap > {{(TIME_W-REG_W){1'b0}}, cfg.sync_min_us};
    assign too_short = gap < {{(TIME_W-REG_W){1'b0}}, cfg.pulse_min_us};
    assign in_range  = !too_short && (gap <= {{(TIME_W-REG_W){1'b0}}, cfg.pulse_max_us});
    assign cur_ext   = {3'b000, chan_reg};

    always_comb begin
        chan_next              = chan_reg;
        frames_next            = frames_reg;
        edges_next             = edges_reg + TIME_W'(1);
        res_next.gap_us        = gap[GAP_OUT_W-1:0];
        res_next.slot_written  = 1'b0;
        res_next.slot_index    = 2'b00;
        res_next.frame_done    = 1'b0;
        if (is_sync) begin
            res_next.gap_class = CLS_SYNC;
            if (chan_reg != '0) begin
                frames_next         = frames_reg + TIME_W'(1);
                res_next.frame_done = 1'b1;
            end
            chan_next = '0;
        end else if (in_range) begin
            res_next.gap_class = CLS_PULSE;
            if (chan_reg < CW'(CHANNELS)) begin
                res_next.slot_written = 1'b1;
                res_next.slot_index   = cur_ext[1:0];
                chan_next             = chan_reg + CW'(1);
            end
        end else if (too_short) begin
            res_next.gap_class = CLS_SHORT;
        end else begin
            res_next.gap_class = CLS_LONG;
        end
        nxt_ext               = {3'b000, chan_next};
        res_next.next_channel = nxt_ext[2:0];
        res_next.frames_seen  = frames_next;
        res_next.edges_seen   = edges_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg   <= '0;
            frames_reg <= '0;
            edges_reg  <= '0;
            valid_reg  <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
            if (in_valid) begin
                chan_reg   <= chan_next;
                frames_reg <= frames_next;
                edges_reg  <= edges_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

/* design/ppm_frame_decoder.sv */
// PPM frame decoder: each request on the s_ side carries one 32-bit timer
// value captured at a rising edge of the PPM signal. The block takes the
// modulo-2^32 interval from the previous edge (from zero after reset),
// divides it by TICKS_PER_US, and classes it as a frame sync (strictly above
// sync_min_us), a channel pulse (within pulse_min_us..pulse_max_us), too short
// or too long. Pulses fill channel slots in order until CHANNELS are taken; a
// sync closes the frame and restarts at channel 0, counting the frame only if
// at least one channel was seen. One result request leaves for every edge.
// The block takes one edge per clock unless m_tready holds a full output
// register; each edge passes through a subtract stage, a reciprocal multiply
// stage for the divide, and the classify / count stage that feeds the output
// register. The whole pipe advances together whenever the output register is
// empty or being taken. Configuration writes go through the cfg_ port, which
// is always ready; write registers only while no edge is in flight.
module ppm_frame_decoder
    import ppm_pkg::*;
#(
    parameter int TICKS_PER_US = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // input edge stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] capture_time

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [103:0]         m_tdata,   // [27:0] gap_us, [29:28] slot_index,
                                            // [32:30] next_channel,
                                            // [64:33] frames_seen,
                                            // [96:65] edges_seen, rest zero
    output logic [2:0]           m_tuser,   // [1:0] gap_class, [2] slot_written
    output logic                 m_tlast,   // frame_done

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    logic              pipe_en;
    logic              gap_valid;
    logic [TIME_W-1:0] gap;
    logic              res_valid;
    ppm_result_t       res;
    ppm_cfg_t          cfg_reg;

    // whole pipe moves when the output slot frees up
    assign pipe_en   = !res_valid || m_tready;
    assign s_tready  = pipe_en;
    assign cfg_ready = 1'b1;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_min_us  <= SYNC_MIN_RST;
            cfg_reg.pulse_min_us <= PULSE_MIN_RST;
            cfg_reg.pulse_max_us <= PULSE_MAX_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_MIN:  cfg_reg.sync_min_us  <= cfg_data;
                REG_PULSE_MIN: cfg_reg.pulse_min_us <= cfg_data;
                REG_PULSE_MAX: cfg_reg.pulse_max_us <= cfg_data;
                default: ;
            endcase
        end
    end

    // interval and tick-to-microsecond conversion
    ppm_gap_unit #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_gap (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (pipe_en),
        .in_valid     (s_tvalid),
        .capture_time (s_tdata),
        .out_valid    (gap_valid),
        .gap          (gap)
    );

    // classification, channel slots and counters
    ppm_frame_tracker u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (gap_valid),
        .gap       (gap),
        .cfg       (cfg_reg),
        .out_valid (res_valid),
        .result    (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {7'd0, res.edges_seen, res.frames_seen, res.next_channel,
                       res.slot_index, res.gap_us};
    assign m_tuser  = {res.slot_written, res.gap_class};
    assign m_tlast  = res.frame_done;

endmodule
